// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the debounce block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BDTH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bdth assertion failed");

// Clocked assertion that is checked during reset as well.
`define BDTH_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bdth assertion failed");

`endif

// ----- sv/bdth_pkg.sv -----
// ---------------------------------------------------------------------------
// bdth_pkg
// Types and constants shared by the button debounce / tap / hold block.
// ---------------------------------------------------------------------------
package bdth_pkg;

	localparam int TimeW   = 32;
	localparam int CfgW    = 16;
	localparam int TapW    = 16;
	localparam int ElapsedW = 16;
	localparam int CfgIdxW = 1;

	localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
	localparam logic [CfgW-1:0] TapWindowRst = 16'd500;

	localparam logic [CfgIdxW-1:0] RegDebounce  = 1'b0;
	localparam logic [CfgIdxW-1:0] RegTapWindow = 1'b1;

	typedef struct packed {
		logic                raw_level;
		logic [TimeW-1:0]    now_ms;
		logic [ElapsedW-1:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic             pressed;
		logic             toggled;
		logic             double_tapped;
		logic [TimeW-1:0] held_ms;
		logic [TapW-1:0]  tap_timer_ms;
	} result_t;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] tap_window_ms;
	} cfg_t;

endpackage

// ----- sv/bdth_core.sv -----
// ---------------------------------------------------------------------------
// bdth_core
// Button state registers and the combinational update for one sample.
// ---------------------------------------------------------------------------
module bdth_core import bdth_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    upd,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [TimeW-1:0] last_change_q;
	logic             prev_raw_q;
	logic             pressed_q;
	logic             toggle_q;
	logic             guard_q;
	logic             dtap_q;
	logic [TapW-1:0]  tap_q;
	logic [TimeW-1:0] hold_q;

	logic [TimeW-1:0] last_change_d;
	logic [TimeW-1:0] since_change;
	logic             stable;
	logic             edge_det;
	logic             tap_over;
	logic             tap_under;
	logic [TapW:0]    tap_sum;
	logic [TimeW:0]   hold_sum;
	logic [TimeW-1:0] hold_base;

	logic             pressed_d;
	logic             toggle_d;
	logic             guard_d;
	logic             dtap_d;
	logic [TapW-1:0]  tap_d;
	logic [TimeW-1:0] hold_d;

	always_comb begin
		last_change_d = (item.raw_level != prev_raw_q) ? item.now_ms : last_change_q;
		since_change  = item.now_ms - last_change_d;
		stable        = since_change > {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms};
		edge_det      = item.raw_level & ~pressed_q;
		tap_over      = tap_q > cfg.tap_window_ms;
		tap_under     = tap_q < cfg.tap_window_ms;
		tap_sum       = {1'b0, tap_q} + {1'b0, item.elapsed_ms};
		// restart the hold count on a press edge that is not at exactly the window
		hold_base     = (edge_det && (tap_over || tap_under)) ? '0 : hold_q;
		hold_sum      = {1'b0, hold_base} + {{(TimeW-ElapsedW+1){1'b0}}, item.elapsed_ms};

		pressed_d = 1'b0;
		toggle_d  = toggle_q;
		guard_d   = guard_q;
		dtap_d    = dtap_q;
		tap_d     = tap_q;
		hold_d    = hold_q;

		if (stable) begin
			pressed_d = item.raw_level;
			if (!guard_q && edge_det) begin
				toggle_d = ~toggle_q;
				guard_d  = 1'b1;
			end else begin
				guard_d = 1'b0;
			end
			if (edge_det && tap_over) begin
				tap_d = '0;
			end else if (edge_det && tap_under) begin
				dtap_d = ~dtap_q;
			end else begin
				tap_d = tap_sum[TapW] ? {TapW{1'b1}} : tap_sum[TapW-1:0];
			end
			if (item.raw_level) begin
				hold_d = hold_sum[TimeW] ? {TimeW{1'b1}} : hold_sum[TimeW-1:0];
			end else begin
				hold_d = hold_base;
			end
		end

		res.pressed       = pressed_d;
		res.toggled       = toggle_d;
		res.double_tapped = dtap_d;
		res.held_ms       = hold_d;
		res.tap_timer_ms  = tap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_change_q <= '0;
			prev_raw_q    <= 1'b0;
			pressed_q     <= 1'b0;
			toggle_q      <= 1'b0;
			guard_q       <= 1'b0;
			dtap_q        <= 1'b0;
			tap_q         <= '0;
			hold_q        <= '0;
		end else if (upd) begin
			last_change_q <= last_change_d;
			prev_raw_q    <= item.raw_level;
			pressed_q     <= pressed_d;
			toggle_q      <= toggle_d;
			guard_q       <= guard_d;
			dtap_q        <= dtap_d;
			tap_q         <= tap_d;
			hold_q        <= hold_d;
		end
	end

endmodule

// ----- sv/button_debounce_tap_hold.sv -----
// ---------------------------------------------------------------------------
// button_debounce_tap_hold
// Debounced button with toggle, double-tap and hold timers.
// ---------------------------------------------------------------------------
// Pipeline: an accepted request goes into the input register, then the state
//   update writes its result into the output register that drives the outputs.
// Throughput: one request per cycle while the output is not stalled; the state
//   update is combinational compare and saturating add logic between the two registers.
// Reset: arst_n clears all button state, empties both stages and loads
//   debounce_ms = 50 and tap_window_ms = 500.
module button_debounce_tap_hold import bdth_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_wdata,
	// sample requests
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                raw_level,
	input  logic [TimeW-1:0]    now_ms,
	input  logic [ElapsedW-1:0] elapsed_ms,
	// results
	output logic                out_valid,
	input  logic                out_stall,
	output logic                pressed,
	output logic                toggled,
	output logic                double_tapped,
	output logic [TimeW-1:0]    held_ms,
	output logic [TapW-1:0]     tap_timer_ms
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    vld_s1;
	result_t res_d;
	result_t res_q;
	logic    out_vld_q;
	logic    adv;
	logic    in_acc;

	// Advance the input stage whenever the output register is free or drains.
	assign adv      = vld_s1 && (!out_vld_q || !out_stall);
	// Hold the input only when the input stage is full and cannot advance.
	assign in_stall = vld_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// Configuration registers; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DebounceRst;
			cfg_q.tap_window_ms <= TapWindowRst;
		end else if (cfg_we) begin
			case (cfg_index)
				RegDebounce:  cfg_q.debounce_ms   <= cfg_wdata;
				RegTapWindow: cfg_q.tap_window_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage: capture the sample request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.raw_level  <= raw_level;
			item_s1.now_ms     <= now_ms;
			item_s1.elapsed_ms <= elapsed_ms;
		end
	end

	// Button state and its update; state commits when the sample advances.
	bdth_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	// Output register: hold the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_vld_q;
	assign pressed       = res_q.pressed;
	assign toggled       = res_q.toggled;
	assign double_tapped = res_q.double_tapped;
	assign held_ms       = res_q.held_ms;
	assign tap_timer_ms  = res_q.tap_timer_ms;

endmodule

// ----- sv/bdth_checker.sv -----
// ---------------------------------------------------------------------------
// bdth_checker
// Port-level checks for the button debounce / tap / hold block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdth_checker import bdth_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic                pressed,
	input logic                toggled,
	input logic                double_tapped,
	input logic [TimeW-1:0]    held_ms,
	input logic [TapW-1:0]     tap_timer_ms
);

	logic [TimeW+TapW+2:0] res_bus;

	assign res_bus = {pressed, toggled, double_tapped, held_ms, tap_timer_ms};

	// input backs up only behind a stalled, full output
	`BDTH_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall))

	// an accepted request is followed by a valid result on the output
	`BDTH_ASSERT(a_latency, clk, arst_n, (in_valid && !in_stall) |-> ##2 out_valid)

	// a stalled result stays put
	`BDTH_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(res_bus)))

	// nothing is presented in the cycle after a reset edge
	`BDTH_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> (!out_valid && !in_stall))

endmodule

bind button_debounce_tap_hold bdth_checker u_bdth_checker (.*);

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for button_debounce_tap_hold: drives button samples
// and register writes, predicts every result in a small checker class and
// compares each returned result field by field in order.
// ---------------------------------------------------------------------------
module tb;
	import bdth_pkg::*;

	// Predicts the debounced level, flags and timers for each accepted
	// request and keeps the results still owed by the block.
	class press_predictor;
		logic [CfgW-1:0]     debounce;
		logic [CfgW-1:0]     window;
		logic [TimeW-1:0]    last_change;
		logic                prev_raw;
		logic                level;
		logic                toggle;
		logic                guard;
		logic                dtap;
		logic [TapW-1:0]     tap;
		logic [TimeW-1:0]    hold;
		result_t             expected_states[$];
		int                  mismatches;

		function new();
			debounce    = DebounceRst;
			window      = TapWindowRst;
			last_change = '0;
			prev_raw    = 1'b0;
			level       = 1'b0;
			toggle      = 1'b0;
			guard       = 1'b0;
			dtap        = 1'b0;
			tap         = '0;
			hold        = '0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
			case (idx)
				RegDebounce: begin
					debounce = val;
				end
				RegTapWindow: begin
					window = val;
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_states.size();
		endfunction

		// Advance the button state by one accepted sample.
		function void take_sample(logic raw, logic [TimeW-1:0] now,
				logic [ElapsedW-1:0] dt);
			logic [TimeW-1:0] since;
			logic             old_level;
			logic             press_edge;
			logic [TapW:0]    tap_sum;
			logic [TimeW:0]   hold_sum;
			result_t          res;

			if (raw != prev_raw)
				last_change = now;
			since = now - last_change;
			if (since > {{(TimeW-CfgW){1'b0}}, debounce}) begin
				old_level  = level;
				level      = raw;
				press_edge = raw && !old_level;
				// the one-shot bit lets a press edge flip the toggle only once
				if (!guard && press_edge) begin
					toggle = ~toggle;
					guard  = 1'b1;
				end else begin
					guard = 1'b0;
				end
				// exactly at the window a press is neither fresh nor double
				if (press_edge && tap > window) begin
					hold = '0;
					tap  = '0;
				end else if (press_edge && tap < window) begin
					hold = '0;
					dtap = ~dtap;
				end else begin
					tap_sum = {1'b0, tap} + {1'b0, dt};
					tap     = tap_sum[TapW] ? '1 : tap_sum[TapW-1:0];
				end
				if (level) begin
					hold_sum = {1'b0, hold} + {{(TimeW-ElapsedW+1){1'b0}}, dt};
					hold     = hold_sum[TimeW] ? '1 : hold_sum[TimeW-1:0];
				end
			end else begin
				level = 1'b0;
			end
			prev_raw = raw;

			res.pressed       = level;
			res.toggled       = toggle;
			res.double_tapped = dtap;
			res.held_ms       = hold;
			res.tap_timer_ms  = tap;
			expected_states.push_back(res);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t %s mismatch: expected %0d, actual %0d",
					$time, name, want, got);
				mismatches++;
			end
		endfunction

		// Check one returned result against the oldest prediction.
		function void match_state(result_t got);
			result_t want;

			if (expected_states.size() == 0) begin
				$display("%0t result with nothing pending: actual %p", $time, got);
				mismatches++;
				return;
			end
			want = expected_states.pop_front();
			compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
			compare_field("toggled", 32'(want.toggled), 32'(got.toggled));
			compare_field("double_tapped", 32'(want.double_tapped),
				32'(got.double_tapped));
			compare_field("held_ms", want.held_ms, got.held_ms);
			compare_field("tap_timer_ms", 32'(want.tap_timer_ms), 32'(got.tap_timer_ms));
		endfunction
	endclass

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index  = '0;
	logic [CfgW-1:0]     cfg_wdata  = '0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic                raw_level  = 1'b0;
	logic [TimeW-1:0]    now_ms     = '0;
	logic [ElapsedW-1:0] elapsed_ms = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic                pressed;
	logic                toggled;
	logic                double_tapped;
	logic [TimeW-1:0]    held_ms;
	logic [TapW-1:0]     tap_timer_ms;

	press_predictor      sb = new();

	// Free-running button clock of the stimulus and the pin level last sent.
	logic [TimeW-1:0]    clock_ms  = '0;
	logic                pin_level = 1'b0;
	// No idling on either side while set.
	bit                  quiet     = 1'b0;

	button_debounce_tap_hold u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.raw_level     (raw_level),
		.now_ms        (now_ms),
		.elapsed_ms    (elapsed_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pressed       (pressed),
		.toggled       (toggled),
		.double_tapped (double_tapped),
		.held_ms       (held_ms),
		.tap_timer_ms  (tap_timer_ms)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Monitor: note each accepted request first, then check each accepted
	// result. Both read the values that held before this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_sample(raw_level, now_ms, elapsed_ms);
			if (out_valid && !out_stall)
				sb.match_state({pressed, toggled, double_tapped, held_ms, tap_timer_ms});
		end
	end

	// Result side back-pressure: alternate free runs and stall runs, mostly
	// short stalls with the odd long one; hold off entirely when quiet.
	initial begin
		int run_left;
		bit stalling;

		run_left = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n || quiet) begin
				stalling = 1'b0;
				run_left = 0;
			end else if (run_left > 0) begin
				run_left--;
			end else if (stalling) begin
				stalling = 1'b0;
				run_left = $urandom_range(0, 15);
			end else begin
				stalling = 1'b1;
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end
			out_stall <= stalling;
		end
	end

	// Present one request and hold it until the block takes it. Valid stays
	// high on return so a following request can go out back to back.
	task automatic send_sample(input logic raw, input logic [TimeW-1:0] now,
			input logic [ElapsedW-1:0] dt);
		int gap;

		gap = 0;
		if (!quiet) begin
			case ($urandom_range(0, 19))
				0:       gap = $urandom_range(10, 40);
				1, 2, 3,
				4, 5:    gap = $urandom_range(1, 3);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		raw_level  <= raw;
		now_ms     <= now;
		elapsed_ms <= dt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Advance the button clock by one step and sample the pin. Elapsed
	// normally follows the clock step but now and then disagrees with it.
	task automatic step_pin(input logic raw, input int step);
		logic [ElapsedW-1:0] dt;

		clock_ms  = clock_ms + step;
		dt        = ($urandom_range(0, 7) == 0) ? ElapsedW'($urandom_range(0, 65535))
			: ElapsedW'(step);
		pin_level = raw;
		send_sample(raw, clock_ms, dt);
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write both registers while the block is idle.
	task automatic configure(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] win);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= RegDebounce;
		cfg_wdata <= deb;
		@(posedge clk);
		sb.set_reg(RegDebounce, deb);
		cfg_index <= RegTapWindow;
		cfg_wdata <= win;
		@(posedge clk);
		sb.set_reg(RegTapWindow, win);
		cfg_we    <= 1'b0;
	endtask

	// Random gestures: a burst of bounces that ends on a target level, then
	// a run of steady samples that may or may not cross the debounce delay. A few
	// runs are broken by a backward time jump, and some samples are noise.
	task automatic run_phase(input int goal, input int deb);
		int   sent;
		int   bounces;
		int   hold_len;
		logic target;

		sent = 0;
		while (sent < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				send_sample(1'($urandom_range(0, 1)), $urandom,
					ElapsedW'($urandom_range(0, 65535)));
				sent++;
			end else begin
				target   = ($urandom_range(0, 3) == 0) ? pin_level : ~pin_level;
				bounces  = $urandom_range(0, 4);
				hold_len = $urandom_range(1, 10);
				repeat (bounces) begin
					step_pin(~pin_level, $urandom_range(0, deb / 8 + 2));
					sent++;
				end
				repeat (hold_len) begin
					if ($urandom_range(0, 15) == 0)
						clock_ms = clock_ms - $urandom_range(1, deb + 1);
					step_pin(target, $urandom_range(1, deb / 2 + 2));
					sent++;
				end
			end
		end
	endtask

	initial begin
		int deb_tab [8];
		int win_tab [8];

		deb_tab = '{0, 65535, 3, 20, 0, 65535, 0, 0};
		win_tab = '{0, 65535, 40, 200, 65535, 0, 0, 0};
		deb_tab[6] = $urandom_range(0, 60);
		win_tab[6] = $urandom_range(0, 400);
		deb_tab[7] = $urandom_range(0, 65535);
		win_tab[7] = $urandom_range(0, 65535);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: settle from time zero, saturate the tap timer in
		// two steps, accept across the 2^32 wrap, fall back to settling on a
		// backward jump, then press again with the one-shot still armed.
		send_sample(1'b0, 32'd0, 16'd0);
		send_sample(1'b0, 32'd51, 16'hFFFF);
		send_sample(1'b0, 32'd60, 16'hFFFF);
		send_sample(1'b1, 32'hFFFF_FFFF, 16'd7);
		send_sample(1'b1, 32'd50, 16'd10);
		send_sample(1'b1, 32'd100, 16'd20);
		send_sample(1'b1, 32'd40, 16'd3);
		send_sample(1'b1, 32'd200, 16'd4);
		send_sample(1'b1, 32'd45, 16'd2);
		send_sample(1'b1, 32'd300, 16'd1);

		// Zero debounce: bring the tap timer exactly to the window, then
		// press on it.
		configure(16'd0, 16'd100);
		send_sample(1'b0, 32'd301, 16'd80);
		send_sample(1'b0, 32'd302, 16'd80);
		send_sample(1'b1, 32'd303, 16'd9);
		send_sample(1'b1, 32'd304, 16'd9);

		// Largest settings: stable only past 65535 ms, press at a saturated
		// tap timer equal to the window.
		configure(16'hFFFF, 16'hFFFF);
		send_sample(1'b0, 32'd305, 16'd1);
		send_sample(1'b0, 32'd65840, 16'hFFFF);
		send_sample(1'b0, 32'd65841, 16'hFFFF);
		send_sample(1'b1, 32'd65842, 16'd5);
		send_sample(1'b1, 32'd131378, 16'd6);

		// Zero window: every press is a fresh one.
		configure(16'd0, 16'd0);
		send_sample(1'b0, 32'd200000, 16'd3);
		send_sample(1'b0, 32'd200001, 16'd3);
		send_sample(1'b1, 32'd200002, 16'd3);
		send_sample(1'b1, 32'd200003, 16'd3);

		clock_ms  = 32'd200010;
		pin_level = 1'b1;
		for (int p = 0; p < 8; p++) begin
			configure(CfgW'(deb_tab[p]), CfgW'(win_tab[p]));
			quiet = (p == 2 || p == 5);
			run_phase(210, deb_tab[p]);
		end

		// Steady press at full elapsed steps, back to back with no idling.
		configure(16'd0, 16'd1000);
		quiet = 1'b1;
		clock_ms = clock_ms + 1;
		send_sample(1'b0, clock_ms, 16'd1);
		clock_ms = clock_ms + 1;
		send_sample(1'b1, clock_ms, 16'd1);
		repeat (20) begin
			clock_ms = clock_ms + 1;
			send_sample(1'b1, clock_ms, 16'hFFFF);
		end
		quiet = 1'b0;
		clock_ms = clock_ms + 1;
		send_sample(1'b0, clock_ms, 16'd1);

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t %0d results never arrived", $time, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
